FILE: design/range_based_speed_governor_top_assert.svh
// ----------------------------------------------------------------------------
// Range-based speed governor assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RANGE_BASED_SPEED_GOVERNOR_TOP_ASSERT_SVH
`define RANGE_BASED_SPEED_GOVERNOR_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define RBSG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbsg: same-cycle check failed");
// next-cycle implication
`define RBSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbsg: next-cycle check failed");
`else
`define RBSG_ASSERT_NOW(label, clk, rst, ante, cons)
`define RBSG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: design/rbsg_pkg.sv
// ----------------------------------------------------------------------------
// Speed governor package
// Shared constants, codes and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package rbsg_pkg;

   // default field widths
   localparam int VEL_BITS_DEF   = 16;
   localparam int RANGE_BITS_DEF = 16;

   // fixed field widths
   localparam int KIND_BITS     = 2;
   localparam int CT_BITS       = 16;
   localparam int DIST_BITS     = 16;
   localparam int LIMIT_BITS    = 15;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   // scaling: distance in mm times 1000 over time in ms gives mm/s
   localparam int SCALE_MS      = 1000;
   localparam int SCALE_BITS    = 10;
   localparam int NEAR_FLOOR_MM = 20;

   // reset values
   localparam logic [CT_BITS-1:0]    CT_RESET    = 16'd1000;
   localparam logic [DIST_BITS-1:0]  DIST_RESET  = 16'd400;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 15'd7000;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_UNSAFE_MODE  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_COLLISION_MS = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_MIN_DIST     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRONT_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_REAR_LIMIT   = 3'd4;

   // velocity axes
   localparam int AXES  = 6;
   localparam int AX_LX = 0;
   localparam int AX_AZ = 5;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_CMD   = 2'd0,
      KIND_FRONT = 2'd1,
      KIND_REAR  = 2'd2,
      KIND_TICK  = 2'd3
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_DIVIDE
   } state_type;

   typedef struct packed {
      logic accept_cmd;
      logic accept_front;
      logic accept_rear;
      logic accept_tick;
      logic div_start;
      logic div_step;
      logic bound_write;
   } rbsg_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     last;
   } rbsg_status_type;

endpackage

`default_nettype wire

FILE: design/rbsg_if.sv
// ----------------------------------------------------------------------------
// Speed governor channels
// Valid/ready interfaces for the item and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbsg_req_if import rbsg_pkg::*; #(
   parameter int VEL_BITS   = VEL_BITS_DEF,
   parameter int RANGE_BITS = RANGE_BITS_DEF
);
   logic                        valid;
   logic                        ready;
   logic [KIND_BITS-1:0]        kind;
   logic [RANGE_BITS-1:0]       range_mm;
   logic                        last_sample;
   logic signed [VEL_BITS-1:0]  cmd_lin_x;
   logic signed [VEL_BITS-1:0]  cmd_lin_y;
   logic signed [VEL_BITS-1:0]  cmd_lin_z;
   logic signed [VEL_BITS-1:0]  cmd_ang_x;
   logic signed [VEL_BITS-1:0]  cmd_ang_y;
   logic signed [VEL_BITS-1:0]  cmd_ang_z;

   modport source (
      output valid, kind, range_mm, last_sample,
             cmd_lin_x, cmd_lin_y, cmd_lin_z, cmd_ang_x, cmd_ang_y, cmd_ang_z,
      input  ready
   );
   modport sink (
      input  valid, kind, range_mm, last_sample,
             cmd_lin_x, cmd_lin_y, cmd_lin_z, cmd_ang_x, cmd_ang_y, cmd_ang_z,
      output ready
   );
endinterface

interface rbsg_rsp_if import rbsg_pkg::*; #(
   parameter int VEL_BITS = VEL_BITS_DEF
);
   logic                        valid;
   logic                        ready;
   logic signed [VEL_BITS-1:0]  safe_lin_x;
   logic signed [VEL_BITS-1:0]  safe_lin_y;
   logic signed [VEL_BITS-1:0]  safe_lin_z;
   logic signed [VEL_BITS-1:0]  safe_ang_x;
   logic signed [VEL_BITS-1:0]  safe_ang_y;
   logic signed [VEL_BITS-1:0]  safe_ang_z;
   logic                        front_missing;
   logic                        rear_missing;

   modport source (
      output valid, safe_lin_x, safe_lin_y, safe_lin_z,
             safe_ang_x, safe_ang_y, safe_ang_z, front_missing, rear_missing,
      input  ready
   );
   modport sink (
      input  valid, safe_lin_x, safe_lin_y, safe_lin_z,
             safe_ang_x, safe_ang_y, safe_ang_z, front_missing, rear_missing,
      output ready
   );
endinterface

`default_nettype wire

FILE: design/range_based_speed_governor_top.sv
// Result: a tick's result is registered and on rsp in the cycle after the tick transfer.
// Flow: commands, ticks and range samples other than the last of a scan can be
// taken back to back, a tick only while rsp is empty or being taken; the last
// sample of a scan holds the input while the bit-serial restoring divider runs.
// Reset: synchronous, active high; all state but the divider and result payload resets.
// ----------------------------------------------------------------------------
// Range-based speed governor top level
// Clamps a held velocity command to speed bounds derived from range scans.
// ----------------------------------------------------------------------------
`default_nettype none

module range_based_speed_governor_top import rbsg_pkg::*; #(
   parameter int VEL_BITS   = VEL_BITS_DEF,
   parameter int RANGE_BITS = RANGE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   rbsg_req_if.sink                 req_if,
   rbsg_rsp_if.source               rsp_if,
   input  logic                     csr_wen,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   rbsg_cmd_type    cmd;
   rbsg_status_type sts;

   // sequence items and results
   rbsg_ctrl #(
      .RANGE_BITS (RANGE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold state and compute
   rbsg_datapath #(
      .VEL_BITS   (VEL_BITS),
      .RANGE_BITS (RANGE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req_if.kind),
      .req_range_mm      (req_if.range_mm),
      .req_last_sample   (req_if.last_sample),
      .req_cmd_lin_x     (req_if.cmd_lin_x),
      .req_cmd_lin_y     (req_if.cmd_lin_y),
      .req_cmd_lin_z     (req_if.cmd_lin_z),
      .req_cmd_ang_x     (req_if.cmd_ang_x),
      .req_cmd_ang_y     (req_if.cmd_ang_y),
      .req_cmd_ang_z     (req_if.cmd_ang_z),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_safe_lin_x    (rsp_if.safe_lin_x),
      .rsp_safe_lin_y    (rsp_if.safe_lin_y),
      .rsp_safe_lin_z    (rsp_if.safe_lin_z),
      .rsp_safe_ang_x    (rsp_if.safe_ang_x),
      .rsp_safe_ang_y    (rsp_if.safe_ang_y),
      .rsp_safe_ang_z    (rsp_if.safe_ang_z),
      .rsp_front_missing (rsp_if.front_missing),
      .rsp_rear_missing  (rsp_if.rear_missing)
   );

endmodule

`default_nettype wire

FILE: design/rbsg_datapath.sv
// ----------------------------------------------------------------------------
// Speed governor datapath
// Registers, command hold/delta logic, scan minimum, bound divider, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsg_datapath import rbsg_pkg::*; #(
   parameter int VEL_BITS   = VEL_BITS_DEF,
   parameter int RANGE_BITS = RANGE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rbsg_cmd_type                cmd,
   output rbsg_status_type             sts,
   input  logic [KIND_BITS-1:0]        req_kind,
   input  logic [RANGE_BITS-1:0]       req_range_mm,
   input  logic                        req_last_sample,
   input  logic signed [VEL_BITS-1:0]  req_cmd_lin_x,
   input  logic signed [VEL_BITS-1:0]  req_cmd_lin_y,
   input  logic signed [VEL_BITS-1:0]  req_cmd_lin_z,
   input  logic signed [VEL_BITS-1:0]  req_cmd_ang_x,
   input  logic signed [VEL_BITS-1:0]  req_cmd_ang_y,
   input  logic signed [VEL_BITS-1:0]  req_cmd_ang_z,
   input  logic                        csr_wen,
   input  logic [CSR_IDX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_wdata,
   output logic signed [VEL_BITS-1:0]  rsp_safe_lin_x,
   output logic signed [VEL_BITS-1:0]  rsp_safe_lin_y,
   output logic signed [VEL_BITS-1:0]  rsp_safe_lin_z,
   output logic signed [VEL_BITS-1:0]  rsp_safe_ang_x,
   output logic signed [VEL_BITS-1:0]  rsp_safe_ang_y,
   output logic signed [VEL_BITS-1:0]  rsp_safe_ang_z,
   output logic                        rsp_front_missing,
   output logic                        rsp_rear_missing
);

   localparam int DIV_BITS   = RANGE_BITS + SCALE_BITS;
   localparam int SUM_BITS   = VEL_BITS + 2;
   localparam int CLAMP_BITS = ((VEL_BITS > LIMIT_BITS) ? VEL_BITS : LIMIT_BITS) + 2;
   localparam int CMP_BITS   = (RANGE_BITS > DIST_BITS) ? RANGE_BITS : DIST_BITS;
   localparam longint VMAX_L = (64'sd1 <<< (VEL_BITS - 1)) - 64'sd1;
   localparam longint VMIN_L = -VMAX_L - 64'sd1;
   localparam logic signed [VEL_BITS-1:0]   VEL_MAX = VEL_BITS'(VMAX_L);
   localparam logic signed [VEL_BITS-1:0]   VEL_MIN = VEL_BITS'(VMIN_L);
   localparam logic signed [SUM_BITS-1:0]   SUM_MAX = SUM_BITS'(VMAX_L);
   localparam logic signed [SUM_BITS-1:0]   SUM_MIN = SUM_BITS'(VMIN_L);
   localparam logic signed [CLAMP_BITS-1:0] CL_MAX  = CLAMP_BITS'(VMAX_L);
   localparam logic signed [CLAMP_BITS-1:0] CL_MIN  = CLAMP_BITS'(VMIN_L);

   // configuration registers
   logic                    unsafe_ff;
   logic [CT_BITS-1:0]      ctime_ff;
   logic [DIST_BITS-1:0]    mindist_ff;
   logic [LIMIT_BITS-1:0]   flimit_ff;
   logic [LIMIT_BITS-1:0]   rlimit_ff;

   // governor state
   logic signed [VEL_BITS-1:0] held_ff [AXES];
   logic signed [VEL_BITS-1:0] held_in [AXES];
   logic signed [VEL_BITS-1:0] prev_ff [AXES];
   logic signed [VEL_BITS-1:0] prev_in [AXES];
   logic [LIMIT_BITS-1:0]      fbound_ff, fbound_in;
   logic [LIMIT_BITS-1:0]      rbound_ff, rbound_in;
   logic [RANGE_BITS-1:0]      fmin_ff, fmin_in;
   logic [RANGE_BITS-1:0]      rmin_ff, rmin_in;
   logic                       fseen_ff, fseen_in;
   logic                       rseen_ff, rseen_in;

   // divider registers
   logic [DIV_BITS-1:0]        quo_ff, quo_in;
   logic [CT_BITS-1:0]         rem_ff, rem_in;
   logic [CT_BITS-1:0]         divisor_ff, divisor_in;
   logic [LIMIT_BITS-1:0]      dlimit_ff, dlimit_in;
   logic                       dzero_ff, dzero_in;
   logic                       dside_ff, dside_in;

   // result registers
   logic signed [VEL_BITS-1:0] safe_ff [AXES];
   logic signed [VEL_BITS-1:0] safe_in [AXES];
   logic                       fmiss_ff, fmiss_in;
   logic                       rmiss_ff, rmiss_in;

   // combinational helpers
   logic signed [VEL_BITS-1:0]   cmd_vec  [AXES];
   logic signed [SUM_BITS-1:0]   sum      [AXES];
   logic signed [VEL_BITS-1:0]   tick_held [AXES];
   logic                         cmd_zero;
   logic signed [CLAMP_BITS-1:0] lx_ext, fb_ext, rb_neg;
   logic [RANGE_BITS-1:0]        fmin_new, rmin_new, scan_min;
   logic                         near_ok;
   logic [CT_BITS:0]             rem_sh;
   logic                         rem_ge;
   logic [LIMIT_BITS-1:0]        bound_cap;

   assign cmd_vec[0] = req_cmd_lin_x;
   assign cmd_vec[1] = req_cmd_lin_y;
   assign cmd_vec[2] = req_cmd_lin_z;
   assign cmd_vec[3] = req_cmd_ang_x;
   assign cmd_vec[4] = req_cmd_ang_y;
   assign cmd_vec[5] = req_cmd_ang_z;

   assign sts.kind = kind_type'(req_kind);
   assign sts.last = req_last_sample;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         unsafe_ff  <= 1'b0;
         ctime_ff   <= CT_RESET;
         mindist_ff <= DIST_RESET;
         flimit_ff  <= LIMIT_RESET;
         rlimit_ff  <= LIMIT_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            REG_UNSAFE_MODE:  unsafe_ff  <= csr_wdata[0];
            REG_COLLISION_MS: ctime_ff   <= csr_wdata[CT_BITS-1:0];
            REG_MIN_DIST:     mindist_ff <= csr_wdata[DIST_BITS-1:0];
            REG_FRONT_LIMIT:  flimit_ff  <= csr_wdata[LIMIT_BITS-1:0];
            REG_REAR_LIMIT:   rlimit_ff  <= csr_wdata[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // command deltas per axis, widened so the hold logic can saturate
   always_comb begin
      cmd_zero = (cmd_vec[AX_LX] == '0) && (cmd_vec[AX_AZ] == '0);
      for (int i = 0; i < AXES; i++) begin
         sum[i] = SUM_BITS'(held_ff[i]) + SUM_BITS'(cmd_vec[i]) - SUM_BITS'(prev_ff[i]);
      end
   end

   // tick clamp of forward and reverse speed
   always_comb begin
      lx_ext = CLAMP_BITS'(held_ff[AX_LX]);
      fb_ext = CLAMP_BITS'(fbound_ff);
      rb_neg = -CLAMP_BITS'(rbound_ff);
      for (int i = 0; i < AXES; i++) begin
         tick_held[i] = held_ff[i];
      end
      if (!unsafe_ff) begin
         if (lx_ext > fb_ext) begin
            tick_held[AX_LX] = (fb_ext > CL_MAX) ? VEL_MAX : fb_ext[VEL_BITS-1:0];
            if (fbound_ff == '0) begin
               tick_held[AX_AZ] = '0;
            end
         end else if (lx_ext < rb_neg) begin
            tick_held[AX_LX] = (rb_neg < CL_MIN) ? VEL_MIN : rb_neg[VEL_BITS-1:0];
            if (rbound_ff == '0) begin
               tick_held[AX_AZ] = '0;
            end
         end
      end
   end

   // hold, delta or clamp the command
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         held_in[i] = held_ff[i];
         prev_in[i] = prev_ff[i];
         safe_in[i] = safe_ff[i];
         if (cmd.accept_cmd) begin
            if (unsafe_ff || cmd_zero) begin
               held_in[i] = cmd_vec[i];
            end else if (sum[i] > SUM_MAX) begin
               held_in[i] = VEL_MAX;
            end else if (sum[i] < SUM_MIN) begin
               held_in[i] = VEL_MIN;
            end else begin
               held_in[i] = sum[i][VEL_BITS-1:0];
            end
            if (!unsafe_ff) begin
               prev_in[i] = cmd_vec[i];
            end
         end else if (cmd.accept_tick) begin
            held_in[i] = tick_held[i];
            safe_in[i] = tick_held[i];
         end
      end
   end

   // scan minimum, near check, seen and missing-scan flags
   always_comb begin
      fmin_new   = (req_range_mm < fmin_ff) ? req_range_mm : fmin_ff;
      rmin_new   = (req_range_mm < rmin_ff) ? req_range_mm : rmin_ff;
      scan_min   = cmd.accept_rear ? rmin_new : fmin_new;
      near_ok    = (CMP_BITS'(scan_min) >= CMP_BITS'(mindist_ff)) &&
                   (scan_min > RANGE_BITS'(NEAR_FLOOR_MM));
      fmin_in    = fmin_ff;
      rmin_in    = rmin_ff;
      fseen_in   = fseen_ff;
      rseen_in   = rseen_ff;
      fmiss_in   = fmiss_ff;
      rmiss_in   = rmiss_ff;
      if (cmd.accept_front) begin
         fmin_in = req_last_sample ? '1 : fmin_new;
         if (req_last_sample) begin
            fseen_in = 1'b1;
         end
      end
      if (cmd.accept_rear) begin
         rmin_in = req_last_sample ? '1 : rmin_new;
         if (req_last_sample) begin
            rseen_in = 1'b1;
         end
      end
      if (cmd.accept_tick) begin
         fmiss_in = !unsafe_ff && !fseen_ff;
         rmiss_in = !unsafe_ff && !rseen_ff;
         if (!unsafe_ff) begin
            fseen_in = 1'b0;
            rseen_in = 1'b0;
         end
      end
   end

   // restoring divider, one quotient bit per step
   always_comb begin
      rem_sh     = {rem_ff, quo_ff[DIV_BITS-1]};
      rem_ge     = rem_sh >= {1'b0, divisor_ff};
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      dlimit_in  = dlimit_ff;
      dzero_in   = dzero_ff;
      dside_in   = dside_ff;
      if (cmd.div_start) begin
         quo_in     = DIV_BITS'(scan_min) * DIV_BITS'(SCALE_MS);
         rem_in     = '0;
         divisor_in = (ctime_ff == '0) ? CT_BITS'(1) : ctime_ff;
         dlimit_in  = cmd.accept_rear ? rlimit_ff : flimit_ff;
         dzero_in   = !near_ok;
         dside_in   = cmd.accept_rear;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[DIV_BITS-2:0], rem_ge};
         rem_in = rem_ge ? CT_BITS'(rem_sh - {1'b0, divisor_ff}) : rem_sh[CT_BITS-1:0];
      end
   end

   // cap the quotient and write the side's bound
   always_comb begin
      if (dzero_ff) begin
         bound_cap = '0;
      end else if (quo_ff > DIV_BITS'(dlimit_ff)) begin
         bound_cap = dlimit_ff;
      end else begin
         bound_cap = quo_ff[LIMIT_BITS-1:0];
      end
      fbound_in = fbound_ff;
      rbound_in = rbound_ff;
      if (cmd.bound_write) begin
         if (dside_ff) begin
            rbound_in = bound_cap;
         end else begin
            fbound_in = bound_cap;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            held_ff[i] <= '0;
            prev_ff[i] <= '0;
         end
         fbound_ff <= LIMIT_RESET;
         rbound_ff <= LIMIT_RESET;
         fmin_ff   <= '1;
         rmin_ff   <= '1;
         fseen_ff  <= 1'b0;
         rseen_ff  <= 1'b0;
      end else begin
         for (int i = 0; i < AXES; i++) begin
            held_ff[i] <= held_in[i];
            prev_ff[i] <= prev_in[i];
         end
         fbound_ff <= fbound_in;
         rbound_ff <= rbound_in;
         fmin_ff   <= fmin_in;
         rmin_ff   <= rmin_in;
         fseen_ff  <= fseen_in;
         rseen_ff  <= rseen_in;
      end
   end

   // divider and result payload
   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      dlimit_ff  <= dlimit_in;
      dzero_ff   <= dzero_in;
      dside_ff   <= dside_in;
      for (int i = 0; i < AXES; i++) begin
         safe_ff[i] <= safe_in[i];
      end
      fmiss_ff <= fmiss_in;
      rmiss_ff <= rmiss_in;
   end

   assign rsp_safe_lin_x    = safe_ff[0];
   assign rsp_safe_lin_y    = safe_ff[1];
   assign rsp_safe_lin_z    = safe_ff[2];
   assign rsp_safe_ang_x    = safe_ff[3];
   assign rsp_safe_ang_y    = safe_ff[4];
   assign rsp_safe_ang_z    = safe_ff[5];
   assign rsp_front_missing = fmiss_ff;
   assign rsp_rear_missing  = rmiss_ff;

endmodule

`default_nettype wire

FILE: design/rbsg_ctrl.sv
// ----------------------------------------------------------------------------
// Speed governor controller
// Handshake, item dispatch, divider sequencing and result valid.
// ----------------------------------------------------------------------------
`default_nettype none
`include "range_based_speed_governor_top_assert.svh"

module rbsg_ctrl import rbsg_pkg::*; #(
   parameter int RANGE_BITS = RANGE_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  rbsg_status_type sts,
   output rbsg_cmd_type    cmd
);

   localparam int DIV_STEPS = RANGE_BITS + SCALE_BITS;
   localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);
   localparam logic [CNT_BITS-1:0] CNT_LOAD = CNT_BITS'(DIV_STEPS);

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                is_sample;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.div_start) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs: ready and datapath commands
   always_comb begin
      req_ready = (state_ff == ST_IDLE) &&
                  ((sts.kind != KIND_TICK) || !rsp_valid_ff || rsp_ready);
      accept    = req_valid && req_ready;
      is_sample = sts.kind inside {KIND_FRONT, KIND_REAR};
      cmd.accept_cmd   = accept && (sts.kind == KIND_CMD);
      cmd.accept_front = accept && (sts.kind == KIND_FRONT);
      cmd.accept_rear  = accept && (sts.kind == KIND_REAR);
      cmd.accept_tick  = accept && (sts.kind == KIND_TICK);
      cmd.div_start    = accept && is_sample && sts.last;
      cmd.div_step     = (state_ff == ST_DIVIDE) && (cnt_ff != '0);
      cmd.bound_write  = (state_ff == ST_DIVIDE) && (cnt_ff == '0);
   end

   // step counter and result valid
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.div_start) begin
         cnt_in = CNT_LOAD;
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.accept_tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RBSG_ASSERT_NEXT(a_div_load, clock, reset, cmd.div_start, (state_ff == ST_DIVIDE) && (cnt_ff == CNT_LOAD))
   `RBSG_ASSERT_NOW(a_busy_stall, clock, reset, state_ff == ST_DIVIDE, !req_ready)
   `RBSG_ASSERT_NEXT(a_div_end, clock, reset, (state_ff == ST_DIVIDE) && (cnt_ff == '0), state_ff == ST_IDLE)
   `RBSG_ASSERT_NEXT(a_tick_result, clock, reset, cmd.accept_tick, rsp_valid)

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed governor testbench
// Drives commands, front and rear scans and control ticks into the governor
// with random idling on both channels, predicts every tick's limited command
// and missing-scan flags, and compares each result transfer field by field.
// ----------------------------------------------------------------------------

module tb_top;
   import rbsg_pkg::*;

   localparam int VB             = VEL_BITS_DEF;
   localparam int RB             = RANGE_BITS_DEF;
   localparam int VEL_MAX        = 2**(VB-1) - 1;
   localparam int VEL_MIN        = -VEL_MAX - 1;
   localparam int RANGE_MAX      = 2**RB - 1;
   localparam int BOUND_SAT      = 2**LIMIT_BITS - 1;
   localparam int IDLE_PCT       = 21;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      kind_type                kind;
      logic [RB-1:0]           range_mm;
      logic                    last;
      logic [AXES-1:0][VB-1:0] vel;
   } gov_item_t;

   typedef struct packed {
      logic [AXES-1:0][VB-1:0] vel;
      logic                    front_missing;
      logic                    rear_missing;
   } safe_cmd_t;

   logic                     clock;
   logic                     reset;
   logic                     csr_wen;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   rbsg_req_if req_bus ();
   rbsg_rsp_if rsp_bus ();

   range_based_speed_governor_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // governor shadow: registers and state
   bit         unsafe_q;
   int         collision_q;
   int         min_dist_q;
   int         front_limit_q;
   int         rear_limit_q;
   longint     held_cmd [AXES];
   longint     prev_cmd [AXES];
   int         front_bound;
   int         rear_bound;
   int         front_min;
   int         rear_min;
   bit         front_seen;
   bit         rear_seen;

   safe_cmd_t  pending_safe_cmds [$];

   // bookkeeping
   int  req_transfers;
   int  results_checked;
   int  items_sent;
   int  settings_applied;
   int  mismatches;
   int  stall_cycles;
   int  hold_left;
   int  rsp_hold_req;
   bit  quiet;

   string axis_name [AXES] = '{"safe_lin_x", "safe_lin_y", "safe_lin_z",
                               "safe_ang_x", "safe_ang_y", "safe_ang_z"};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic longint clamp_vel(input longint v);
      if (v > VEL_MAX) return VEL_MAX;
      if (v < VEL_MIN) return VEL_MIN;
      return v;
   endfunction

   // speed allowed by the closest obstacle of one scan
   function automatic int speed_bound(input int min_mm, input int cap);
      longint quotient;
      longint divisor;
      quotient = 0;
      divisor  = (collision_q == 0) ? 1 : collision_q;
      if (min_mm >= min_dist_q && min_mm > NEAR_FLOOR_MM) begin
         quotient = min_mm;
         quotient = (quotient * SCALE_MS) / divisor;
      end
      if (quotient > cap) quotient = cap;
      if (quotient > BOUND_SAT) quotient = BOUND_SAT;
      return int'(quotient);
   endfunction

   // advance the shadow by one accepted item, queue a result on a tick
   task automatic predict_governor(input gov_item_t it);
      longint    cmd [AXES];
      safe_cmd_t res;
      bit        zero_cmd;
      for (int a = 0; a < AXES; a++) cmd[a] = $signed(it.vel[a]);
      case (it.kind)
         KIND_CMD: begin
            if (unsafe_q) begin
               for (int a = 0; a < AXES; a++) held_cmd[a] = cmd[a];
            end else begin
               zero_cmd = (cmd[AX_LX] == 0) && (cmd[AX_AZ] == 0);
               for (int a = 0; a < AXES; a++) begin
                  if (zero_cmd) held_cmd[a] = cmd[a];
                  else held_cmd[a] = clamp_vel(held_cmd[a] + (cmd[a] - prev_cmd[a]));
                  prev_cmd[a] = cmd[a];
               end
            end
         end
         KIND_FRONT: begin
            if (it.range_mm < front_min) front_min = int'(it.range_mm);
            if (it.last) begin
               front_bound = speed_bound(front_min, front_limit_q);
               front_min   = RANGE_MAX;
               front_seen  = 1'b1;
            end
         end
         KIND_REAR: begin
            if (it.range_mm < rear_min) rear_min = int'(it.range_mm);
            if (it.last) begin
               rear_bound = speed_bound(rear_min, rear_limit_q);
               rear_min   = RANGE_MAX;
               rear_seen  = 1'b1;
            end
         end
         KIND_TICK: begin
            res.front_missing = 1'b0;
            res.rear_missing  = 1'b0;
            if (!unsafe_q) begin
               res.front_missing = !front_seen;
               res.rear_missing  = !rear_seen;
               front_seen = 1'b0;
               rear_seen  = 1'b0;
               if (held_cmd[AX_LX] > front_bound) begin
                  held_cmd[AX_LX] = front_bound;
                  if (front_bound == 0) held_cmd[AX_AZ] = 0;
               end else if (held_cmd[AX_LX] < -longint'(rear_bound)) begin
                  held_cmd[AX_LX] = -longint'(rear_bound);
                  if (rear_bound == 0) held_cmd[AX_AZ] = 0;
               end
            end
            for (int a = 0; a < AXES; a++) res.vel[a] = held_cmd[a][VB-1:0];
            pending_safe_cmds.push_back(res);
         end
      endcase
   endtask

   // sample every port at the rising edge: registers, item transfers, results
   always @(posedge clock) begin : scoreboard
      safe_cmd_t               want;
      logic [AXES-1:0][VB-1:0] got;
      gov_item_t               it;
      if (reset) begin
         unsafe_q      = 1'b0;
         collision_q   = int'(CT_RESET);
         min_dist_q    = int'(DIST_RESET);
         front_limit_q = int'(LIMIT_RESET);
         rear_limit_q  = int'(LIMIT_RESET);
         for (int a = 0; a < AXES; a++) begin
            held_cmd[a] = 0;
            prev_cmd[a] = 0;
         end
         front_bound = int'(LIMIT_RESET);
         rear_bound  = int'(LIMIT_RESET);
         front_min   = RANGE_MAX;
         rear_min    = RANGE_MAX;
         front_seen  = 1'b0;
         rear_seen   = 1'b0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               REG_UNSAFE_MODE:  unsafe_q      = csr_wdata[0];
               REG_COLLISION_MS: collision_q   = int'(csr_wdata);
               REG_MIN_DIST:     min_dist_q    = int'(csr_wdata);
               REG_FRONT_LIMIT:  front_limit_q = int'(csr_wdata[LIMIT_BITS-1:0]);
               REG_REAR_LIMIT:   rear_limit_q  = int'(csr_wdata[LIMIT_BITS-1:0]);
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            it.kind     = kind_type'(req_bus.kind);
            it.range_mm = req_bus.range_mm;
            it.last     = req_bus.last_sample;
            it.vel[0]   = req_bus.cmd_lin_x;
            it.vel[1]   = req_bus.cmd_lin_y;
            it.vel[2]   = req_bus.cmd_lin_z;
            it.vel[3]   = req_bus.cmd_ang_x;
            it.vel[4]   = req_bus.cmd_ang_y;
            it.vel[5]   = req_bus.cmd_ang_z;
            predict_governor(it);
            req_transfers++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_safe_cmds.size() == 0) begin
               report_mismatch("result transfer with no expectation waiting");
            end else begin
               want   = pending_safe_cmds.pop_front();
               got[0] = rsp_bus.safe_lin_x;
               got[1] = rsp_bus.safe_lin_y;
               got[2] = rsp_bus.safe_lin_z;
               got[3] = rsp_bus.safe_ang_x;
               got[4] = rsp_bus.safe_ang_y;
               got[5] = rsp_bus.safe_ang_z;
               for (int a = 0; a < AXES; a++)
                  if (got[a] !== want.vel[a])
                     report_mismatch($sformatf("result %0d %s: got %0d expected %0d",
                        results_checked, axis_name[a], $signed(got[a]),
                        $signed(want.vel[a])));
               if (rsp_bus.front_missing !== want.front_missing)
                  report_mismatch($sformatf("result %0d front_missing: got %b expected %b",
                     results_checked, rsp_bus.front_missing, want.front_missing));
               if (rsp_bus.rear_missing !== want.rear_missing)
                  report_mismatch($sformatf("result %0d rear_missing: got %b expected %b",
                     results_checked, rsp_bus.rear_missing, want.rear_missing));
            end
            results_checked++;
         end
      end
   end

   // pace the result side: random holds, or a long hold-off on request
   always @(negedge clock) begin : rsp_pacing
      if (rsp_hold_req != 0) begin
         hold_left    = rsp_hold_req;
         rsp_hold_req = 0;
      end
      if (hold_left > 0) begin
         rsp_bus.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready = quiet || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin : watchdog
      if (reset || csr_wen || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles without any transfer, %0d results outstanding",
                  stall_cycles, pending_safe_cmds.size());
         $display("range_based_speed_governor_top regression: fail");
         $finish;
      end
   end

   // offer one item after an optional gap; return at the falling edge after its transfer
   task automatic send_item(input gov_item_t it);
      int seen;
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.kind        = it.kind;
      req_bus.range_mm    = it.range_mm;
      req_bus.last_sample = it.last;
      req_bus.cmd_lin_x   = it.vel[0];
      req_bus.cmd_lin_y   = it.vel[1];
      req_bus.cmd_lin_z   = it.vel[2];
      req_bus.cmd_ang_x   = it.vel[3];
      req_bus.cmd_ang_y   = it.vel[4];
      req_bus.cmd_ang_z   = it.vel[5];
      req_bus.valid       = 1'b1;
      seen = req_transfers;
      @(negedge clock);
      while (req_transfers == seen) @(negedge clock);
      items_sent++;
   endtask

   function automatic gov_item_t cmd_item(input int lx, input int ly, input int lz,
                                          input int ax, input int ay, input int az);
      gov_item_t it;
      it          = '0;
      it.kind     = KIND_CMD;
      it.range_mm = RB'($urandom_range(RANGE_MAX));
      it.vel[0]   = lx[VB-1:0];
      it.vel[1]   = ly[VB-1:0];
      it.vel[2]   = lz[VB-1:0];
      it.vel[3]   = ax[VB-1:0];
      it.vel[4]   = ay[VB-1:0];
      it.vel[5]   = az[VB-1:0];
      return it;
   endfunction

   function automatic gov_item_t sample_item(input kind_type k, input int r, input bit last);
      gov_item_t it;
      it          = '0;
      it.kind     = k;
      it.range_mm = r[RB-1:0];
      it.last     = last;
      for (int a = 0; a < AXES; a++) it.vel[a] = VB'($urandom);
      return it;
   endfunction

   // hold valid low, wait out every result and any divide still running
   task automatic drain_block();
      req_bus.valid = 1'b0;
      while (pending_safe_cmds.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_settings(input bit unsafe, input int ct, input int md,
                                 input int fl, input int rl);
      drain_block();
      csr_wen   = 1'b1;
      csr_index = REG_UNSAFE_MODE;
      csr_wdata = {{(CSR_DATA_BITS-1){1'b0}}, unsafe};
      @(negedge clock);
      csr_index = REG_COLLISION_MS;
      csr_wdata = ct[CSR_DATA_BITS-1:0];
      @(negedge clock);
      csr_index = REG_MIN_DIST;
      csr_wdata = md[CSR_DATA_BITS-1:0];
      @(negedge clock);
      csr_index = REG_FRONT_LIMIT;
      csr_wdata = {1'b0, fl[LIMIT_BITS-1:0]};
      @(negedge clock);
      csr_index = REG_REAR_LIMIT;
      csr_wdata = {1'b0, rl[LIMIT_BITS-1:0]};
      @(negedge clock);
      csr_wen = 1'b0;
      settings_applied++;
   endtask

   function automatic int pick_vel();
      case ($urandom_range(4))
         0: begin
            case ($urandom_range(4))
               0:       return VEL_MAX;
               1:       return VEL_MIN;
               2:       return 0;
               3:       return 1;
               default: return -1;
            endcase
         end
         1:       return int'($urandom_range(2**VB - 1)) + VEL_MIN;
         default: return int'($urandom_range(16000)) - 8000;
      endcase
   endfunction

   // ranges near the floor, near the threshold, at the extremes and in between
   function automatic int pick_range();
      int v;
      case ($urandom_range(5))
         0: return $urandom_range(40);
         1: begin
            v = min_dist_q + int'($urandom_range(6)) - 3;
            if (v < 0) v = 0;
            if (v > RANGE_MAX) v = RANGE_MAX;
            return v;
         end
         2:       return $urandom_range(RANGE_MAX);
         3:       return ($urandom_range(1) != 0) ? RANGE_MAX : 0;
         default: return $urandom_range(100, 8000);
      endcase
   endfunction

   function automatic int pick_collision_ms();
      case ($urandom_range(4))
         0:       return 0;
         1:       return 2**CT_BITS - 1;
         2:       return $urandom_range(1, 300);
         default: return $urandom_range(1, 60000);
      endcase
   endfunction

   // mostly whole scans, commands and ticks; some malformed noise
   task automatic send_traffic(input int n_items, input int tick_pct);
      int        sent;
      int        pick;
      int        len;
      int        lx;
      int        az;
      kind_type  side;
      gov_item_t it;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            side = (pick < 28) ? KIND_FRONT : KIND_REAR;
            len  = ($urandom_range(9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
            for (int j = 0; j < len; j++)
               send_item(sample_item(side, pick_range(), j == len - 1));
            sent += len;
         end else if (pick < 76) begin
            lx = 0;
            az = 0;
            if ($urandom_range(4) != 0) begin
               lx = pick_vel();
               az = pick_vel();
            end
            send_item(cmd_item(lx, pick_vel(), pick_vel(), pick_vel(), pick_vel(), az));
            sent++;
         end else if (pick < 76 + tick_pct) begin
            send_item(sample_item(KIND_TICK, $urandom_range(RANGE_MAX),
                                  1'($urandom_range(1))));
            sent++;
         end else begin
            it          = sample_item(kind_type'(2'($urandom_range(3))),
                                      $urandom_range(RANGE_MAX), 1'($urandom_range(1)));
            it.vel[0]   = VB'(pick_vel());
            it.vel[5]   = VB'(pick_vel());
            send_item(it);
            sent++;
         end
      end
   endtask

   // tick straight after reset: zero command, both scans missing
   task automatic test_reset_state();
      send_item(sample_item(KIND_TICK, 0, 1'b0));
   endtask

   // replace on zero command, delta otherwise, saturation at both ends
   task automatic test_command_rules();
      send_item(cmd_item(0, 5, -5, 7, -7, 0));
      send_item(cmd_item(100, 200, -300, 400, -500, 600));
      send_item(cmd_item(VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX));
      send_item(cmd_item(VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN));
      send_item(sample_item(KIND_TICK, RANGE_MAX, 1'b1));
   endtask

   // obstacle at the floor blocks and stops turning; limit caps a far scan
   task automatic test_scan_bounds();
      send_item(sample_item(KIND_FRONT, RANGE_MAX, 1'b0));
      send_item(sample_item(KIND_FRONT, NEAR_FLOOR_MM, 1'b1));
      send_item(sample_item(KIND_REAR, RANGE_MAX, 1'b1));
      send_item(cmd_item(0, 9, 0, 0, 0, 0));
      send_item(cmd_item(5000, 9, 0, 0, 0, 300));
      send_item(sample_item(KIND_TICK, 0, 1'b0));
      send_item(sample_item(KIND_TICK, 0, 1'b0));
      send_item(sample_item(KIND_FRONT, DIST_RESET, 1'b1));
      send_item(cmd_item(-30000, 1, 2, 3, 4, 5));
      send_item(sample_item(KIND_TICK, 0, 1'b0));
   endtask

   // unsafe mode passes commands through and keeps the scan flags
   task automatic test_unsafe_passthrough();
      write_settings(1'b1, CT_RESET, DIST_RESET, 0, 0);
      send_item(cmd_item(VEL_MAX, -1, 1, 0, 0, VEL_MIN));
      send_item(sample_item(KIND_FRONT, 10, 1'b1));
      send_item(sample_item(KIND_TICK, 0, 1'b0));
      write_settings(1'b0, CT_RESET, DIST_RESET, 0, 0);
      send_item(sample_item(KIND_TICK, 0, 1'b0));
   endtask

   // zero collision time divides by one; the rear bound saturates
   task automatic test_collision_time_zero();
      write_settings(1'b0, 0, 0, BOUND_SAT, BOUND_SAT);
      send_item(sample_item(KIND_FRONT, 30, 1'b1));
      send_item(sample_item(KIND_REAR, RANGE_MAX, 1'b1));
      send_item(cmd_item(VEL_MAX, 0, 0, 0, 0, 1));
      send_item(sample_item(KIND_TICK, 0, 1'b0));
   endtask

   // random traffic under a series of settings, defaults and extremes first
   task automatic test_random_traffic();
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: write_settings(1'b0, CT_RESET, DIST_RESET, LIMIT_RESET, LIMIT_RESET);
            1: write_settings(1'b0, 1, 0, BOUND_SAT, BOUND_SAT);
            2: write_settings(1'b0, 60000, 2**DIST_BITS - 1, 0, 0);
            3: write_settings(1'b0, 0, NEAR_FLOOR_MM + 1,
                              $urandom_range(BOUND_SAT), $urandom_range(BOUND_SAT));
            4: write_settings(1'b1, pick_collision_ms(), $urandom_range(1000),
                              $urandom_range(BOUND_SAT), $urandom_range(BOUND_SAT));
            default: write_settings(1'b0, pick_collision_ms(), $urandom_range(1000),
                                    $urandom_range(BOUND_SAT), $urandom_range(BOUND_SAT));
         endcase
         // one phase runs with no idling on either side
         quiet = (phase == 5);
         send_traffic(140, 14);
      end
      quiet = 1'b0;
   endtask

   // stall the result side for a long stretch while items keep coming
   task automatic test_output_backpressure();
      write_settings(1'b0, pick_collision_ms(), $urandom_range(1000),
                     $urandom_range(BOUND_SAT), $urandom_range(BOUND_SAT));
      rsp_hold_req = HOLD_CYCLES;
      send_traffic(120, 25);
   endtask

   initial begin
      reset               = 1'b1;
      csr_wen             = 1'b0;
      csr_index           = REG_UNSAFE_MODE;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.kind        = KIND_CMD;
      req_bus.range_mm    = '0;
      req_bus.last_sample = 1'b0;
      req_bus.cmd_lin_x   = '0;
      req_bus.cmd_lin_y   = '0;
      req_bus.cmd_lin_z   = '0;
      req_bus.cmd_ang_x   = '0;
      req_bus.cmd_ang_y   = '0;
      req_bus.cmd_ang_z   = '0;
      rsp_bus.ready       = 1'b0;
      quiet               = 1'b0;
      rsp_hold_req        = 0;
      hold_left           = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_command_rules();
      test_scan_bounds();
      test_unsafe_passthrough();
      test_collision_time_zero();
      test_random_traffic();
      test_output_backpressure();
      drain_block();

      $display("covered %0d items and %0d tick results over %0d register settings,",
               items_sent, results_checked, settings_applied);
      $display("including unsafe mode, zero collision time and a %0d-cycle result stall",
               HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("range_based_speed_governor_top regression: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("range_based_speed_governor_top regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/rbsg_pkg.sv
design/rbsg_if.sv
design/rbsg_datapath.sv
design/rbsg_ctrl.sv
design/range_based_speed_governor_top.sv
tb/tb_top.sv
